// ===== sv/scc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package scc_pkg;

  localparam int unsigned MODE_W      = 2;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned SLOT_W      = 6;
  localparam int unsigned SECTOR_W    = 32;
  localparam int unsigned MAX_RESULTS = 64;
  localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);

  typedef enum logic [MODE_W-1:0] {
    MODE_READ  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_FLUSH = 2'd2
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_HIT         = 3'd0,
    ST_MISS_FREE   = 3'd1,
    ST_MISS_CLEAN  = 3'd2,
    ST_MISS_DIRTY  = 3'd3,
    ST_FLUSH_WB    = 3'd4,
    ST_FLUSH_NONE  = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_HIT,
    S_SWEEP,
    S_VICTIM,
    S_FL_SCAN,
    S_FL_CAP,
    S_FL_END
  } ctrl_state_e;

  // Commands from the controller to the datapath, at most one per cycle.
  typedef struct packed {
    logic start;
    logic probe;
    logic hit_upd;
    logic hand_adv;
    logic victim_rd;
    logic victim_upd;
    logic fl_next;
    logic fl_rd;
    logic fl_cap;
    logic fl_end;
  } dp_cmd_t;

  typedef struct packed {
    logic hit;
    logic cmp_last;
    logic hand_take;
    logic fl_dirty;
    logic idx_last;
    logic cnt_last;
    logic out_busy;
    logic pend_busy;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== sv/scc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module scc_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [scc_pkg::MODE_W-1:0]    mode_i,
  input  scc_pkg::dp_stat_t             stat_i,
  output scc_pkg::dp_cmd_t              cmd_o
);
  import scc_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          unique case (mode_i)
            MODE_READ, MODE_WRITE: state_d = S_LOOKUP;
            MODE_FLUSH:            state_d = S_FL_SCAN;
            default:               state_d = S_IDLE;  // drop unknown requests
          endcase
        end
      end
      S_LOOKUP: begin
        if (stat_i.hit) begin
          state_d = S_HIT;
        end else if (stat_i.cmp_last) begin
          state_d = S_SWEEP;
        end else begin
          cmd_o.probe = 1'b1;
        end
      end
      S_HIT: begin
        if (!stat_i.out_busy) begin
          cmd_o.hit_upd = 1'b1;
          state_d       = S_IDLE;
        end
      end
      S_SWEEP: begin
        if (stat_i.hand_take) begin
          cmd_o.victim_rd = 1'b1;
          state_d         = S_VICTIM;
        end else begin
          cmd_o.hand_adv = 1'b1;
        end
      end
      S_VICTIM: begin
        if (!stat_i.out_busy) begin
          cmd_o.victim_upd = 1'b1;
          state_d          = S_IDLE;
        end
      end
      S_FL_SCAN: begin
        if (stat_i.fl_dirty) begin
          cmd_o.fl_rd = 1'b1;
          state_d     = S_FL_CAP;
        end else if (stat_i.idx_last) begin
          state_d = S_FL_END;
        end else begin
          cmd_o.fl_next = 1'b1;
        end
      end
      S_FL_CAP: begin
        if (!stat_i.pend_busy) begin
          cmd_o.fl_cap = 1'b1;
          state_d      = (stat_i.idx_last || stat_i.cnt_last) ? S_FL_END : S_FL_SCAN;
        end
      end
      S_FL_END: begin
        if (!stat_i.out_busy) begin
          cmd_o.fl_end = 1'b1;
          state_d      = S_IDLE;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/scc_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module scc_dpath #(
  parameter int unsigned SLOTS       = 64,
  parameter int unsigned SECTOR_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [scc_pkg::MODE_W-1:0]    mode_i,
  input  logic [scc_pkg::SECTOR_W-1:0]  sector_i,
  input  scc_pkg::dp_cmd_t              cmd_i,
  output scc_pkg::dp_stat_t             stat_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [scc_pkg::STATUS_W-1:0]  status_o,
  output logic [scc_pkg::SLOT_W-1:0]    slot_o,
  output logic                          writeback_needed_o,
  output logic [scc_pkg::SECTOR_W-1:0]  writeback_sector_o,
  output logic                          fill_needed_o,
  output logic                          last_o
);
  import scc_pkg::*;

  localparam int unsigned IDX_W = $clog2(SLOTS);
  localparam int unsigned TAG_W = (SECTOR_BITS < SECTOR_W) ? SECTOR_BITS : SECTOR_W;
  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(SLOTS - 1);

  // Tag store: one write and one registered read port
  logic [TAG_W-1:0] tag_mem [SLOTS];
  logic [TAG_W-1:0] tag_rd_q;
  logic [IDX_W-1:0] rd_addr;
  logic             rd_en;

  logic [SLOTS-1:0] valid_q, dirty_q, ref_q;
  logic [IDX_W-1:0] hand_q, idx_q, cmp_idx_q, pend_slot_q;
  logic             cmp_vld_q, pend_vld_q, is_write_q;
  logic [TAG_W-1:0] req_tag_q, pend_tag_q;
  logic [CNT_W-1:0] cnt_q;
  logic             push, out_busy;

  logic [IDX_W-1:0] hand_inc, idx_inc;

  assign hand_inc = (hand_q == IDX_MAX) ? '0 : hand_q + 1'b1;
  assign idx_inc  = (idx_q == IDX_MAX) ? '0 : idx_q + 1'b1;
  assign out_busy = out_valid_o && !out_ready_i;

  assign rd_en   = cmd_i.probe || cmd_i.fl_rd || cmd_i.victim_rd;
  assign rd_addr = cmd_i.victim_rd ? hand_q : idx_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.victim_upd) begin
      tag_mem[hand_q] <= req_tag_q;
    end
    if (rd_en) begin
      tag_rd_q <= tag_mem[rd_addr];
    end
  end

  assign stat_o.hit       = cmp_vld_q && valid_q[cmp_idx_q] && (tag_rd_q == req_tag_q);
  assign stat_o.cmp_last  = cmp_vld_q && (cmp_idx_q == IDX_MAX);
  assign stat_o.hand_take = !valid_q[hand_q] || !ref_q[hand_q];
  assign stat_o.fl_dirty  = valid_q[idx_q] && dirty_q[idx_q];
  assign stat_o.idx_last  = (idx_q == IDX_MAX);
  assign stat_o.cnt_last  = (cnt_q == CNT_W'(MAX_RESULTS - 1));
  assign stat_o.out_busy  = out_busy;
  assign stat_o.pend_busy = pend_vld_q && out_busy;

  // Request, scan and slot state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      dirty_q    <= '0;
      ref_q      <= '0;
      hand_q     <= '0;
      idx_q      <= '0;
      cmp_idx_q  <= '0;
      cmp_vld_q  <= 1'b0;
      pend_vld_q <= 1'b0;
      cnt_q      <= '0;
    end else begin
      cmp_vld_q <= cmd_i.probe;
      if (cmd_i.start) begin
        idx_q      <= '0;
        cnt_q      <= '0;
        pend_vld_q <= 1'b0;
      end
      if (cmd_i.probe) begin
        cmp_idx_q <= idx_q;
        idx_q     <= idx_inc;
      end
      if (cmd_i.hit_upd) begin
        ref_q[cmp_idx_q] <= 1'b1;
        if (is_write_q) begin
          dirty_q[cmp_idx_q] <= 1'b1;
        end
      end
      if (cmd_i.hand_adv) begin
        ref_q[hand_q] <= 1'b0;
        hand_q        <= hand_inc;
      end
      if (cmd_i.victim_upd) begin
        valid_q[hand_q] <= 1'b1;
        dirty_q[hand_q] <= is_write_q;
        ref_q[hand_q]   <= 1'b1;
      end
      if (cmd_i.fl_next) begin
        idx_q <= idx_inc;
      end
      if (cmd_i.fl_cap) begin
        dirty_q[idx_q] <= 1'b0;
        pend_vld_q     <= 1'b1;
        cnt_q          <= cnt_q + 1'b1;
        idx_q          <= idx_inc;
      end
      if (cmd_i.fl_end) begin
        pend_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      req_tag_q  <= sector_i[TAG_W-1:0];
      is_write_q <= (mode_i == MODE_WRITE);
    end
    if (cmd_i.fl_cap) begin
      pend_slot_q <= idx_q;
      pend_tag_q  <= tag_rd_q;
    end
  end

  // Output register
  assign push = cmd_i.hit_upd || cmd_i.victim_upd || cmd_i.fl_end ||
                (cmd_i.fl_cap && pend_vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (push) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    priority if (cmd_i.hit_upd) begin
      status_o           <= ST_HIT;
      slot_o             <= SLOT_W'(cmp_idx_q);
      writeback_needed_o <= 1'b0;
      writeback_sector_o <= '0;
      fill_needed_o      <= 1'b0;
      last_o             <= 1'b1;
    end else if (cmd_i.victim_upd) begin
      if (!valid_q[hand_q]) begin
        status_o <= ST_MISS_FREE;
      end else if (dirty_q[hand_q]) begin
        status_o <= ST_MISS_DIRTY;
      end else begin
        status_o <= ST_MISS_CLEAN;
      end
      slot_o             <= SLOT_W'(hand_q);
      writeback_needed_o <= valid_q[hand_q] && dirty_q[hand_q];
      writeback_sector_o <= (valid_q[hand_q] && dirty_q[hand_q]) ?
                            SECTOR_W'(tag_rd_q) : '0;
      fill_needed_o      <= 1'b1;
      last_o             <= 1'b1;
    end else if (cmd_i.fl_end && !pend_vld_q) begin
      status_o           <= ST_FLUSH_NONE;
      slot_o             <= '0;
      writeback_needed_o <= 1'b0;
      writeback_sector_o <= '0;
      fill_needed_o      <= 1'b0;
      last_o             <= 1'b1;
    end else if (cmd_i.fl_end || (cmd_i.fl_cap && pend_vld_q)) begin
      // release the held flush item; it is final only at the end of the walk
      status_o           <= ST_FLUSH_WB;
      slot_o             <= SLOT_W'(pend_slot_q);
      writeback_needed_o <= 1'b1;
      writeback_sector_o <= SECTOR_W'(pend_tag_q);
      fill_needed_o      <= 1'b0;
      last_o             <= cmd_i.fl_end;
    end else begin
      status_o <= status_o;
    end
  end

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd_i))
    else $error("more than one datapath command");

  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !out_busy)
    else $error("result pushed over an untaken result");

  a_flush_dirty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fl_cap |-> (valid_q[idx_q] && dirty_q[idx_q]))
    else $error("flush captured a clean or invalid slot");

  a_victim_installed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.victim_upd |=> (valid_q[hand_q] && ref_q[hand_q]))
    else $error("victim slot not installed");

endmodule

`default_nettype wire

// ===== sv/sector_cache_clock_replacement_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake              Payload
// in       input      in_valid_i/in_ready_o  mode_i, sector_i
// out      output     out_valid_o/out_ready_i status_o, slot_o, writeback_needed_o,
//                                            writeback_sector_o, fill_needed_o, last_o
//
// One request at a time. Lookup reads the tag memory one slot per cycle up to
// a hit or miss decision; a miss then sweeps the clock hand one slot per cycle
// to a victim, then reads the victim slot and installs the new tag there.
// Flush walks clean slots one per cycle; each dirty slot is read and then captured.
// Reset clears valid, dirty and reference bits and the hand; tags are not cleared.
// A stalled output holds the controller only where it has a result to place.
module sector_cache_clock_replacement_core #(
  parameter int unsigned SLOTS       = 64,
  parameter int unsigned SECTOR_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [scc_pkg::MODE_W-1:0]    mode_i,
  input  logic [scc_pkg::SECTOR_W-1:0]  sector_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [scc_pkg::STATUS_W-1:0]  status_o,
  output logic [scc_pkg::SLOT_W-1:0]    slot_o,
  output logic                          writeback_needed_o,
  output logic [scc_pkg::SECTOR_W-1:0]  writeback_sector_o,
  output logic                          fill_needed_o,
  output logic                          last_o
);
  import scc_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  scc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .mode_i     (mode_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  scc_dpath #(
    .SLOTS       (SLOTS),
    .SECTOR_BITS (SECTOR_BITS)
  ) u_dpath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .mode_i             (mode_i),
    .sector_i           (sector_i),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .status_o           (status_o),
    .slot_o             (slot_o),
    .writeback_needed_o (writeback_needed_o),
    .writeback_sector_o (writeback_sector_o),
    .fill_needed_o      (fill_needed_o),
    .last_o             (last_o)
  );

endmodule

`default_nettype wire
